>>> src/oahs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_pkg
// Shared codes, state type and controller/datapath interface structs for the
// open-addressing hash set.
// ----------------------------------------------------------------------------
package oahs_pkg;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;
    localparam int ENTRY_W  = 6;
    localparam int LIMIT_W  = 6;
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd25;

    localparam logic [KIND_W-1:0] KIND_CONTAINS = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ISSUE,
        ST_CHECK,
        ST_DECIDE,
        ST_CLEAR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic check;
        logic decide;
        logic sweep;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_clear;
        logic in_probe;
        logic stop;
        logic sweep_last;
        logic out_free;
    } dp_sts_t;

endpackage : oahs_pkg
`default_nettype wire

>>> src/oahs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oahs_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : oahs_ram
`default_nettype wire

>>> src/oahs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_ctrl
// Sequencer for the hash set: clearing pass, probe issue/check loop, update,
// and hand-off of the result beat to the output register.
// ----------------------------------------------------------------------------
module oahs_ctrl
    import oahs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire dp_sts_t   sts,
    output ctrl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.in_clear)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (sts.in_probe)
                    begin
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // keep the read port busy; a read past the stop is dropped
                cmd.check = 1'b1;
                cmd.issue = 1'b1;
                if (sts.stop)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_RESP;
            end
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    a_check_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> ($past(state_reg) == ST_ISSUE ||
                                   $past(state_reg) == ST_CHECK))
        else $error("probe check entered without a read in flight");

    a_decide_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE |=> state_reg == ST_RESP)
        else $error("update did not hand off to the result stage");

endmodule : oahs_ctrl
`default_nettype wire

>>> src/oahs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_datapath
// Bucket RAM, probe address generator, hit/free tracking, live count and
// the output register of the hash set.
// ----------------------------------------------------------------------------
module oahs_datapath
    import oahs_pkg::*;
#(
    parameter int BUCKETS  = 32,
    parameter int KEY_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctrl_cmd_t           cmd,
    output dp_sts_t                  sts,
    input  wire logic [KIND_W-1:0]   kind,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [HASH_W-1:0]   hash_value,
    input  wire logic                cfg_write_en,
    input  wire logic [LIMIT_W-1:0]  cfg_write_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     found,
    output logic [STATUS_W-1:0]      status,
    output logic [SLOT_W-1:0]        slot,
    output logic [ENTRY_W-1:0]       entry_total
);

    localparam int IW = $clog2(BUCKETS);
    localparam int LW = $clog2(BUCKETS + 1);
    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int DW = KW + 2;
    localparam int CW = ((LW > LIMIT_W) ? LW : LIMIT_W) + 1;

    // request
    logic [KIND_W-1:0]  kind_reg;
    logic [KW-1:0]      key_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // probe sequence
    logic [IW-1:0]      addr_reg;
    logic [IW-1:0]      step_reg;
    logic [IW-1:0]      cur_reg;
    logic               last_reg;
    logic [IW-1:0]      sweep_reg;

    // probe outcome
    logic               hit_reg;
    logic [IW-1:0]      hit_slot_reg;
    logic               free_reg;
    logic [IW-1:0]      free_slot_reg;

    // result
    logic               found_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [IW-1:0]      slot_reg;
    logic [LW-1:0]      live_reg;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [ENTRY_W-1:0] out_total_reg;

    // RAM word: {occupied, tombstone, key}
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [DW-1:0]      ram_wdata;
    logic [DW-1:0]      ram_rdata;
    logic               rd_occ;
    logic               rd_tomb;
    logic               rd_eq;

    // update decision
    logic               dec_we;
    logic [IW-1:0]      dec_addr;
    logic [DW-1:0]      dec_data;
    logic               found_next;
    logic [STATUS_W-1:0] status_next;
    logic [IW-1:0]      slot_next;
    logic [LW-1:0]      live_next;
    logic [CW-1:0]      live_inc;
    logic               limit_hit;

    oahs_ram #(
        .WIDTH (DW),
        .DEPTH (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_occ  = ram_rdata[DW-1];
    assign rd_tomb = ram_rdata[DW-2];
    assign rd_eq   = (ram_rdata[KW-1:0] == key_reg);

    always_comb
    begin
        sts.in_clear   = (kind == KIND_CLEAR);
        sts.in_probe   = kind inside {KIND_CONTAINS, KIND_ADD, KIND_SET, KIND_REMOVE};
        sts.stop       = (!rd_occ && !rd_tomb) || (rd_occ && rd_eq) || last_reg;
        sts.sweep_last = (sweep_reg == IW'(BUCKETS - 1));
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign live_inc  = CW'(live_reg) + CW'(1);
    assign limit_hit = live_inc > CW'(limit_reg);

    always_comb
    begin
        dec_we      = 1'b0;
        dec_addr    = hit_slot_reg;
        dec_data    = {1'b1, 1'b0, key_reg};
        found_next  = 1'b0;
        status_next = STATUS_OK;
        slot_next   = '0;
        live_next   = live_reg;
        case (kind_reg)
            KIND_CONTAINS:
            begin
                if (hit_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = hit_slot_reg;
                end
                else
                begin
                    status_next = STATUS_NOTFOUND;
                end
            end
            KIND_REMOVE:
            begin
                if (hit_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = hit_slot_reg;
                    dec_we     = 1'b1;
                    dec_data   = {1'b0, 1'b1, key_reg};
                    live_next  = live_reg - LW'(1);
                end
                else
                begin
                    status_next = STATUS_NOTFOUND;
                end
            end
            KIND_ADD, KIND_SET:
            begin
                if (hit_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = hit_slot_reg;
                    if (kind_reg == KIND_ADD)
                    begin
                        status_next = STATUS_PRESENT;
                    end
                    else
                    begin
                        dec_we = 1'b1;
                    end
                end
                else if (limit_hit || !free_reg)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    dec_we    = 1'b1;
                    dec_addr  = free_slot_reg;
                    slot_next = free_slot_reg;
                    live_next = live_reg + LW'(1);
                end
            end
            default:
            begin
                dec_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = cmd.sweep || (cmd.decide && dec_we);
        ram_waddr = cmd.sweep ? sweep_reg : dec_addr;
        ram_wdata = cmd.sweep ? '0 : dec_data;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            live_reg      <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                limit_reg <= cfg_write_data;
            end
            if (cmd.accept)
            begin
                sweep_reg <= '0;
                hit_reg   <= 1'b0;
                free_reg  <= 1'b0;
                last_reg  <= 1'b0;
            end
            if (cmd.sweep)
            begin
                sweep_reg <= sweep_reg + IW'(1);
                live_reg  <= '0;
            end
            if (cmd.issue)
            begin
                last_reg <= (step_reg == IW'(BUCKETS - 1));
            end
            if (cmd.check)
            begin
                if (!rd_occ && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
                if (rd_occ && rd_eq)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.decide)
            begin
                live_reg <= live_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= kind;
            key_reg    <= key[KW-1:0];
            addr_reg   <= hash_value[IW-1:0];
            step_reg   <= '0;
            found_reg  <= 1'b0;
            status_reg <= STATUS_OK;
            slot_reg   <= '0;
        end
        if (cmd.issue)
        begin
            // triangular step: advance by probe number plus one
            cur_reg  <= addr_reg;
            addr_reg <= addr_reg + step_reg + IW'(1);
            step_reg <= step_reg + IW'(1);
        end
        if (cmd.check)
        begin
            if (!rd_occ && !free_reg)
            begin
                free_slot_reg <= cur_reg;
            end
            if (rd_occ && rd_eq)
            begin
                hit_slot_reg <= cur_reg;
            end
        end
        if (cmd.decide)
        begin
            found_reg  <= found_next;
            status_reg <= status_next;
            slot_reg   <= slot_next;
        end
        if (cmd.load_out)
        begin
            out_found_reg  <= found_reg;
            out_status_reg <= status_reg;
            out_slot_reg   <= SLOT_W'(slot_reg);
            out_total_reg  <= ENTRY_W'(live_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign status      = out_status_reg;
    assign slot        = out_slot_reg;
    assign entry_total = out_total_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LW'(BUCKETS))
        else $error("live count above bucket count");

    a_found_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && found_next |-> hit_reg)
        else $error("found reported without a probe hit");

    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && status_next == STATUS_FULL |=> live_reg == $past(live_reg))
        else $error("refused insert changed the live count");

endmodule : oahs_datapath
`default_nettype wire

>>> src/open_addressing_hash_set.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_set
// Fixed-size open-addressing hash set with triangular probing and tombstones.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  kind, key, hash_value
//   out       source     out_valid/out_stall  found, status, slot, entry_total
//   cfg       sink       cfg_write_en         cfg_write_data (occupancy limit)
//
// Contains/add/set/remove probe p buckets, p from 1 to BUCKETS, through the
// one-probe-per-cycle read port of the bucket RAM.
// Clear wipes the bucket RAM, one RAM row cleared per cycle.
// After reset a clearing pass over every bucket runs before the first beat.
// A result waits in the output register; the next beat is accepted meanwhile,
// and the block holds in its result stage only while that register is full and stalled.
// ----------------------------------------------------------------------------
module open_addressing_hash_set
    import oahs_pkg::*;
#(
    parameter int BUCKETS  = 32,
    parameter int KEY_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [KIND_W-1:0]   kind,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [HASH_W-1:0]   hash_value,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     found,
    output logic [STATUS_W-1:0]      status,
    output logic [SLOT_W-1:0]        slot,
    output logic [ENTRY_W-1:0]       entry_total,
    input  wire logic                cfg_write_en,
    input  wire logic [LIMIT_W-1:0]  cfg_write_data
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    oahs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    oahs_datapath #(
        .BUCKETS  (BUCKETS),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .key            (key),
        .hash_value     (hash_value),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .status         (status),
        .slot           (slot),
        .entry_total    (entry_total)
    );

endmodule : open_addressing_hash_set
`default_nettype wire
